// File: rtl/efs_pkg.sv
// Shared types and constants of the earliest-free server scheduler.
package efs_pkg;

    localparam int MAX_SERVERS_DEF = 16;
    localparam int MODE_W          = 2;
    localparam int SIDX_W          = 4;
    localparam int RATE_W          = 16;
    localparam int COUNT_W         = 16;
    localparam int TIME_W          = 32;
    localparam int ACTIVE_W        = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_JOB    = 2'd1,
        MODE_FINISH = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_SCAN_MIN,
        OP_SCAN_MAX,
        OP_RATE_RD,
        OP_MUL,
        OP_UPDATE,
        OP_REPORT
    } op_t;

    typedef struct packed {
        logic accept;
        op_t  op;
    } cmd_t;

endpackage

// File: rtl/efs_datapath.sv
// Datapath of the scheduler: rate and busy-time memories, scan, multiply and result registers.
module efs_datapath #(
    parameter int MAX_SERVERS = efs_pkg::MAX_SERVERS_DEF,
    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  efs_pkg::cmd_t                     cmd,
    input  logic [IDX_W-1:0]                  cmd_idx,
    input  logic [efs_pkg::MODE_W-1:0]        mode,
    input  logic [efs_pkg::SIDX_W-1:0]        server_index,
    input  logic [efs_pkg::RATE_W-1:0]        unit_rate,
    input  logic [efs_pkg::COUNT_W-1:0]       item_count,
    output logic [efs_pkg::MODE_W-1:0]        result_kind,
    output logic [efs_pkg::SIDX_W-1:0]        assigned_server,
    output logic [efs_pkg::TIME_W-1:0]        start_time,
    output logic [efs_pkg::TIME_W-1:0]        total_time
);

    function automatic logic [efs_pkg::TIME_W-1:0] sat_add(
        input logic [efs_pkg::TIME_W-1:0] a,
        input logic [efs_pkg::TIME_W-1:0] b
    );
        logic [efs_pkg::TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[efs_pkg::TIME_W] ? '1 : sum[efs_pkg::TIME_W-1:0];
    endfunction

    logic [efs_pkg::RATE_W-1:0]  rate_mem [MAX_SERVERS];
    logic [efs_pkg::TIME_W-1:0]  busy_mem [MAX_SERVERS];
    logic [MAX_SERVERS-1:0]      rate_vld_reg;
    logic [MAX_SERVERS-1:0]      busy_vld_reg;

    efs_pkg::mode_t              mode_reg;
    logic [efs_pkg::COUNT_W-1:0] count_reg;

    efs_pkg::op_t                st_op_reg;
    logic [IDX_W-1:0]            st_idx_reg;
    logic [efs_pkg::TIME_W-1:0]  rd_busy_reg;
    logic                        rd_bvld_reg;

    logic [efs_pkg::TIME_W-1:0]  ext_reg;
    logic [IDX_W-1:0]            best_reg;
    logic [efs_pkg::RATE_W-1:0]  rate_rd_reg;
    logic                        rate_rv_reg;
    logic [efs_pkg::TIME_W-1:0]  prod_reg;
    logic [efs_pkg::TIME_W-1:0]  elapsed_reg;

    logic [efs_pkg::MODE_W-1:0]  kind_reg;
    logic [efs_pkg::SIDX_W-1:0]  server_reg;
    logic [efs_pkg::TIME_W-1:0]  start_reg;
    logic [efs_pkg::TIME_W-1:0]  total_reg;

    logic [efs_pkg::TIME_W-1:0]  cur_busy;
    logic [efs_pkg::TIME_W-1:0]  busy_next;
    logic [efs_pkg::RATE_W-1:0]  rate_eff;
    logic                        rate_wr;
    logic [IDX_W-1:0]            rate_waddr;

    assign cur_busy   = rd_bvld_reg ? rd_busy_reg : '0;
    assign rate_eff   = rate_rv_reg ? rate_rd_reg : '0;
    assign rate_wr    = cmd.accept && (efs_pkg::mode_t'(mode) == efs_pkg::MODE_LOAD)
                        && (int'(server_index) < MAX_SERVERS);
    assign rate_waddr = IDX_W'(server_index);

    always_comb
    begin
        if (st_idx_reg == best_reg)
        begin
            busy_next = prod_reg;
        end
        else if (cur_busy > ext_reg)
        begin
            busy_next = cur_busy - ext_reg;
        end
        else
        begin
            busy_next = '0;
        end
    end

    // Memories and payload registers.
    always_ff @(posedge clk)
    begin
        rd_busy_reg <= busy_mem[cmd_idx];
        st_idx_reg  <= cmd_idx;

        if (rate_wr)
        begin
            rate_mem[rate_waddr] <= unit_rate;
        end

        if (cmd.accept)
        begin
            mode_reg  <= efs_pkg::mode_t'(mode);
            count_reg <= item_count;
        end

        case (st_op_reg)
            efs_pkg::OP_SCAN_MIN:
            begin
                if (st_idx_reg == '0 || cur_busy < ext_reg)
                begin
                    ext_reg  <= cur_busy;
                    best_reg <= st_idx_reg;
                end
            end
            efs_pkg::OP_SCAN_MAX:
            begin
                if (st_idx_reg == '0 || cur_busy > ext_reg)
                begin
                    ext_reg <= cur_busy;
                end
            end
            efs_pkg::OP_UPDATE:
            begin
                busy_mem[st_idx_reg] <= busy_next;
            end
            default:
            begin
            end
        endcase

        case (cmd.op)
            efs_pkg::OP_RATE_RD:
            begin
                rate_rd_reg <= rate_mem[best_reg];
            end
            efs_pkg::OP_MUL:
            begin
                prod_reg <= efs_pkg::TIME_W'(rate_eff) * efs_pkg::TIME_W'(count_reg);
            end
            efs_pkg::OP_REPORT:
            begin
                kind_reg   <= mode_reg;
                server_reg <= (mode_reg == efs_pkg::MODE_JOB)
                              ? efs_pkg::SIDX_W'(best_reg) : '0;
                start_reg  <= (mode_reg == efs_pkg::MODE_JOB) ? elapsed_reg : '0;
                total_reg  <= (mode_reg == efs_pkg::MODE_FINISH)
                              ? sat_add(elapsed_reg, ext_reg) : '0;
            end
            default:
            begin
            end
        endcase
    end

    // Control state: pipeline stage tag, valid bits and elapsed time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_op_reg    <= efs_pkg::OP_IDLE;
            rd_bvld_reg  <= 1'b0;
            rate_rv_reg  <= 1'b0;
            rate_vld_reg <= '0;
            busy_vld_reg <= '0;
            elapsed_reg  <= '0;
        end
        else
        begin
            st_op_reg   <= cmd.op;
            rd_bvld_reg <= busy_vld_reg[cmd_idx];

            if (rate_wr)
            begin
                rate_vld_reg[rate_waddr] <= 1'b1;
            end

            if (st_op_reg == efs_pkg::OP_UPDATE)
            begin
                busy_vld_reg[st_idx_reg] <= 1'b1;
            end

            case (cmd.op)
                efs_pkg::OP_RATE_RD:
                begin
                    rate_rv_reg <= rate_vld_reg[best_reg];
                end
                efs_pkg::OP_MUL:
                begin
                    elapsed_reg <= sat_add(elapsed_reg, ext_reg);
                end
                efs_pkg::OP_REPORT:
                begin
                    if (mode_reg == efs_pkg::MODE_FINISH)
                    begin
                        busy_vld_reg <= '0;
                        elapsed_reg  <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result_kind     = kind_reg;
    assign assigned_server = server_reg;
    assign start_time      = start_reg;
    assign total_time      = total_reg;

endmodule

// File: rtl/efs_ctrl.sv
// Controller of the scheduler: sequences the scan, multiply, update and report steps.
module efs_ctrl #(
    parameter int MAX_SERVERS = efs_pkg::MAX_SERVERS_DEF,
    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [efs_pkg::MODE_W-1:0]    mode,
    input  logic                          cfg_we,
    input  logic [efs_pkg::ACTIVE_W-1:0]  cfg_data,
    output logic                          busy,
    output logic                          done,
    output efs_pkg::cmd_t                 cmd,
    output logic [IDX_W-1:0]              cmd_idx
);

    localparam int CNT_W = $clog2(MAX_SERVERS + 1);
    localparam int CMP_W = (CNT_W > efs_pkg::ACTIVE_W) ? CNT_W : efs_pkg::ACTIVE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_DRAIN,
        S_RATE,
        S_MUL,
        S_UPD,
        S_UPD_DRAIN,
        S_REPORT
    } state_t;

    state_t                        state_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic                          fin_reg;
    logic                          done_reg;
    logic [efs_pkg::ACTIVE_W-1:0]  active_reg;

    logic [CNT_W-1:0]              used_n;
    logic                          last_all;
    logic                          last_used;

    always_comb
    begin
        if (active_reg == '0)
        begin
            used_n = CNT_W'(1);
        end
        else if (CMP_W'(active_reg) > CMP_W'(MAX_SERVERS))
        begin
            used_n = CNT_W'(MAX_SERVERS);
        end
        else
        begin
            used_n = CNT_W'(active_reg);
        end
    end

    assign last_all  = (idx_reg == IDX_W'(MAX_SERVERS - 1));
    assign last_used = ((CNT_W'(idx_reg) + CNT_W'(1)) == used_n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            fin_reg    <= 1'b0;
            done_reg   <= 1'b0;
            active_reg <= efs_pkg::ACTIVE_W'(1);
        end
        else
        begin
            done_reg <= (state_reg == S_REPORT);
            if (cfg_we)
            begin
                active_reg <= cfg_data;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (start)
                    begin
                        unique case (efs_pkg::mode_t'(mode)) inside
                            efs_pkg::MODE_JOB:
                            begin
                                fin_reg   <= 1'b0;
                                state_reg <= S_SCAN;
                            end
                            efs_pkg::MODE_FINISH:
                            begin
                                fin_reg   <= 1'b1;
                                state_reg <= S_SCAN;
                            end
                            efs_pkg::MODE_LOAD, efs_pkg::MODE_UNUSED:
                            begin
                                state_reg <= S_REPORT;
                            end
                            default:
                            begin
                                state_reg <= S_REPORT;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (fin_reg ? last_all : last_used)
                    begin
                        state_reg <= S_SCAN_DRAIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                S_SCAN_DRAIN:
                begin
                    state_reg <= fin_reg ? S_REPORT : S_RATE;
                end
                S_RATE:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (last_all)
                    begin
                        state_reg <= S_UPD_DRAIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                S_UPD_DRAIN:
                begin
                    state_reg <= S_REPORT;
                end
                S_REPORT:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd.accept = start && (state_reg == S_IDLE);
        unique case (state_reg)
            S_SCAN:   cmd.op = fin_reg ? efs_pkg::OP_SCAN_MAX : efs_pkg::OP_SCAN_MIN;
            S_RATE:   cmd.op = efs_pkg::OP_RATE_RD;
            S_MUL:    cmd.op = efs_pkg::OP_MUL;
            S_UPD:    cmd.op = efs_pkg::OP_UPDATE;
            S_REPORT: cmd.op = efs_pkg::OP_REPORT;
            default:  cmd.op = efs_pkg::OP_IDLE;
        endcase
    end

    assign cmd_idx = idx_reg;
    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;

endmodule

// File: rtl/earliest_free_server_scheduler.sv
// Top level of the earliest-free server scheduler: controller and datapath.
//
//   Channel   Handshake              Payload
//   -------   --------------------   ---------------------------------------------
//   input     start & !busy          mode, server_index, unit_rate, item_count
//   result    done (one cycle)       result_kind, assigned_server, start_time,
//                                    total_time
//   config    cfg_we                 cfg_data (active server count)
//
// A rate load or an unused mode goes from accept straight to the report step and its done beat.
// A job makes two passes over the busy-time memory, one entry a cycle through its
// single read and write port: the first, over the active entries, finds the earliest
// free server; the second, over every entry, counts the other busy times down and
// loads the chosen server's with its rate times the item count.
// A finish makes a single pass over every entry that finds the longest busy time.
// A new beat can be accepted in the same cycle as the previous done beat.
// Reset clears the rate and busy-time tables through valid bits at once, so no
// clearing pass is needed. The result beat cannot be stalled by the receiver; the
// result registers hold their value until the next beat is reported.
module earliest_free_server_scheduler #(
    parameter int MAX_SERVERS = efs_pkg::MAX_SERVERS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [efs_pkg::MODE_W-1:0]    mode,
    input  logic [efs_pkg::SIDX_W-1:0]    server_index,
    input  logic [efs_pkg::RATE_W-1:0]    unit_rate,
    input  logic [efs_pkg::COUNT_W-1:0]   item_count,
    input  logic                          cfg_we,
    input  logic [efs_pkg::ACTIVE_W-1:0]  cfg_data,
    output logic                          done,
    output logic [efs_pkg::MODE_W-1:0]    result_kind,
    output logic [efs_pkg::SIDX_W-1:0]    assigned_server,
    output logic [efs_pkg::TIME_W-1:0]    start_time,
    output logic [efs_pkg::TIME_W-1:0]    total_time
);

    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

    // Command from the controller: accept strobe and the step the datapath performs,
    // together with the table entry addressed in the current pass.
    efs_pkg::cmd_t     cmd;
    logic [IDX_W-1:0]  cmd_idx;

    efs_ctrl #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .mode     (mode),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .busy     (busy),
        .done     (done),
        .cmd      (cmd),
        .cmd_idx  (cmd_idx)
    );

    // The datapath holds the tables, the elapsed time and the result registers.
    efs_datapath #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cmd_idx         (cmd_idx),
        .mode            (mode),
        .server_index    (server_index),
        .unit_rate       (unit_rate),
        .item_count      (item_count),
        .result_kind     (result_kind),
        .assigned_server (assigned_server),
        .start_time      (start_time),
        .total_time      (total_time)
    );

endmodule

// File: rtl/efs_checker.sv
// Port-level checker of the scheduler and its bind to the top level.
module efs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [efs_pkg::MODE_W-1:0]    result_kind,
    input logic [efs_pkg::SIDX_W-1:0]    assigned_server,
    input logic [efs_pkg::TIME_W-1:0]    start_time
);

    // A done beat lasts exactly one cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
    else $error("done held for more than one cycle");

    // Every accepted beat makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

    // The block becomes free exactly as it reports a result.
    a_free_reports: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
    else $error("busy fell without a done beat");

    // A result other than a job assignment carries no server and no start time.
    a_non_job_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_kind != efs_pkg::MODE_JOB)
            |-> (assigned_server == '0 && start_time == '0))
    else $error("non-job result carries job fields");

endmodule

bind earliest_free_server_scheduler efs_checker u_efs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .result_kind     (result_kind),
    .assigned_server (assigned_server),
    .start_time      (start_time)
);
